[sv/mpool_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the streaming 2-D max pooling block.
package mpool_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int IDX_W      = 6;
   localparam int CSR_DATA_W = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int DIM_CFG_W  = 7;
   localparam int POOL_CFG_W = 4;

   localparam logic [SAMPLE_W-1:0] EMBED_OFFSET = 16'h4000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_CHANNEL_COUNT    = 3'd0,
      REG_MAP_HEIGHT       = 3'd1,
      REG_MAP_WIDTH        = 3'd2,
      REG_POOL_STRIDE      = 3'd3,
      REG_POOL_KERNEL      = 3'd4,
      REG_INPUT_TRANSPOSED = 3'd5,
      REG_EMBED_ADJUST     = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      ADJ_NONE    = 2'd0,
      ADJ_SUB_IN  = 2'd1,
      ADJ_ADD_OUT = 2'd2
   } adjust_type;

   typedef struct packed {
      logic [DIM_CFG_W-1:0]  channel_count;
      logic [DIM_CFG_W-1:0]  map_height;
      logic [DIM_CFG_W-1:0]  map_width;
      logic [POOL_CFG_W-1:0] pool_stride;
      logic [POOL_CFG_W-1:0] pool_kernel;
      logic                  input_transposed;
      logic [1:0]            embed_adjust;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      channel_count:    7'd1,
      map_height:       7'd8,
      map_width:        7'd8,
      pool_stride:      4'd2,
      pool_kernel:      4'd2,
      input_transposed: 1'b0,
      embed_adjust:     2'd0
   };

   // Window status of the word at the head of the stream.
   typedef struct packed {
      logic             hit;
      logic             first;
      logic             last;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] chan;
   } win_type;

   typedef struct packed {
      logic s1_valid;
      logic s1_result;
   } stat_type;

endpackage

[sv/mpool_ctrl.sv]
`timescale 1ns / 1ps
// Stream position counters and window decode for the max pooling block.
module mpool_ctrl #(
   parameter int MAX_DIM = 64,
   parameter int MAX_CHANNELS = 64,
   localparam int PW = $clog2(MAX_DIM),
   localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                restart,
   input  logic                advance,
   input  mpool_pkg::cfg_type  cfg,
   output mpool_pkg::win_type  win,
   output logic [PW+CW-1:0]    slot
);

   localparam int DEW = (PW + 1 > mpool_pkg::DIM_CFG_W) ? PW + 1 : mpool_pkg::DIM_CFG_W;
   localparam int CEW = (CW + 1 > mpool_pkg::DIM_CFG_W) ? CW + 1 : mpool_pkg::DIM_CFG_W;
   localparam int IW  = (PW > mpool_pkg::IDX_W) ? PW : mpool_pkg::IDX_W;
   localparam int CIW = (CW > mpool_pkg::IDX_W) ? CW : mpool_pkg::IDX_W;

   logic [CW-1:0] chan_ff, chan_in;
   logic [PW-1:0] inner_pos_ff, inner_pos_in;
   logic [PW-1:0] outer_pos_ff, outer_pos_in;
   logic [PW-1:0] pool_inner_ff, pool_inner_in;
   logic [PW-1:0] pool_outer_ff, pool_outer_in;
   logic [mpool_pkg::POOL_CFG_W-1:0] inner_phase_ff, inner_phase_in;
   logic [mpool_pkg::POOL_CFG_W-1:0] outer_phase_ff, outer_phase_in;

   logic [CEW-1:0] chans_raw, chans_eff;
   logic [DEW-1:0] height_raw, height_eff, width_raw, width_eff;
   logic [DEW-1:0] outer_dim, inner_dim;
   logic [mpool_pkg::POOL_CFG_W-1:0] stride_eff, kern_raw, kern_eff;
   logic           fit_outer, fit_inner, hit;
   logic           chan_end, inner_end, outer_end, inner_wrap, outer_wrap;
   logic [IW-1:0]  row_x, col_x;
   logic [CIW-1:0] chan_x;

   // Effective sizes: zero acts as one, oversize clamps, kernel never exceeds stride.
   always_comb begin
      chans_raw  = CEW'(cfg.channel_count);
      height_raw = DEW'(cfg.map_height);
      width_raw  = DEW'(cfg.map_width);
      if (chans_raw == '0) begin
         chans_eff = CEW'(1);
      end else if (chans_raw > CEW'(MAX_CHANNELS)) begin
         chans_eff = CEW'(MAX_CHANNELS);
      end else begin
         chans_eff = chans_raw;
      end
      if (height_raw == '0) begin
         height_eff = DEW'(1);
      end else if (height_raw > DEW'(MAX_DIM)) begin
         height_eff = DEW'(MAX_DIM);
      end else begin
         height_eff = height_raw;
      end
      if (width_raw == '0) begin
         width_eff = DEW'(1);
      end else if (width_raw > DEW'(MAX_DIM)) begin
         width_eff = DEW'(MAX_DIM);
      end else begin
         width_eff = width_raw;
      end
      stride_eff = (cfg.pool_stride == '0) ? 4'd1 : cfg.pool_stride;
      kern_raw   = (cfg.pool_kernel == '0) ? 4'd1 : cfg.pool_kernel;
      kern_eff   = (kern_raw > stride_eff) ? stride_eff : kern_raw;
      outer_dim  = cfg.input_transposed ? width_eff : height_eff;
      inner_dim  = cfg.input_transposed ? height_eff : width_eff;
   end

   // A window counts only if its whole stride fits inside the map.
   always_comb begin
      fit_outer = (DEW'(outer_pos_ff - PW'(outer_phase_ff)) + DEW'(stride_eff)) <= outer_dim;
      fit_inner = (DEW'(inner_pos_ff - PW'(inner_phase_ff)) + DEW'(stride_eff)) <= inner_dim;
      hit = fit_outer && fit_inner && (outer_phase_ff < kern_eff) && (inner_phase_ff < kern_eff);
      row_x  = cfg.input_transposed ? IW'(pool_inner_ff) : IW'(pool_outer_ff);
      col_x  = cfg.input_transposed ? IW'(pool_outer_ff) : IW'(pool_inner_ff);
      chan_x = CIW'(chan_ff);
      win.hit   = hit;
      win.first = hit && (outer_phase_ff == '0) && (inner_phase_ff == '0);
      win.last  = hit && (outer_phase_ff == kern_eff - 4'd1) &&
                  (inner_phase_ff == kern_eff - 4'd1);
      win.row   = row_x[mpool_pkg::IDX_W-1:0];
      win.col   = col_x[mpool_pkg::IDX_W-1:0];
      win.chan  = chan_x[mpool_pkg::IDX_W-1:0];
      slot      = {pool_inner_ff, chan_ff};
   end

   always_comb begin
      chan_end   = (CEW'(chan_ff) + CEW'(1)) >= chans_eff;
      inner_end  = (DEW'(inner_pos_ff) + DEW'(1)) >= inner_dim;
      outer_end  = (DEW'(outer_pos_ff) + DEW'(1)) >= outer_dim;
      inner_wrap = (inner_phase_ff + 4'd1) >= stride_eff;
      outer_wrap = (outer_phase_ff + 4'd1) >= stride_eff;

      chan_in        = chan_ff;
      inner_pos_in   = inner_pos_ff;
      inner_phase_in = inner_phase_ff;
      pool_inner_in  = pool_inner_ff;
      outer_pos_in   = outer_pos_ff;
      outer_phase_in = outer_phase_ff;
      pool_outer_in  = pool_outer_ff;

      if (advance) begin
         if (!chan_end) begin
            chan_in = chan_ff + CW'(1);
         end else begin
            chan_in = '0;
            if (!inner_end) begin
               inner_pos_in   = inner_pos_ff + PW'(1);
               inner_phase_in = inner_wrap ? '0 : inner_phase_ff + 4'd1;
               pool_inner_in  = inner_wrap ? pool_inner_ff + PW'(1) : pool_inner_ff;
            end else begin
               inner_pos_in   = '0;
               inner_phase_in = '0;
               pool_inner_in  = '0;
               if (!outer_end) begin
                  outer_pos_in   = outer_pos_ff + PW'(1);
                  outer_phase_in = outer_wrap ? '0 : outer_phase_ff + 4'd1;
                  pool_outer_in  = outer_wrap ? pool_outer_ff + PW'(1) : pool_outer_ff;
               end else begin
                  outer_pos_in   = '0;
                  outer_phase_in = '0;
                  pool_outer_in  = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         chan_ff        <= '0;
         inner_pos_ff   <= '0;
         inner_phase_ff <= '0;
         pool_inner_ff  <= '0;
         outer_pos_ff   <= '0;
         outer_phase_ff <= '0;
         pool_outer_ff  <= '0;
      end else begin
         chan_ff        <= chan_in;
         inner_pos_ff   <= inner_pos_in;
         inner_phase_ff <= inner_phase_in;
         pool_inner_ff  <= pool_inner_in;
         outer_pos_ff   <= outer_pos_in;
         outer_phase_ff <= outer_phase_in;
         pool_outer_ff  <= pool_outer_in;
      end
   end

endmodule

[sv/mpool_datapath.sv]
`timescale 1ns / 1ps
// Partial maximum memory, compare stage and result register.
module mpool_datapath #(
   parameter int MAX_DIM = 64,
   parameter int MAX_CHANNELS = 64,
   localparam int PW = $clog2(MAX_DIM),
   localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
   localparam int AW = PW + CW
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  take,
   input  logic signed [mpool_pkg::SAMPLE_W-1:0] sample,
   input  mpool_pkg::win_type                    win,
   input  logic [AW-1:0]                         slot,
   input  logic [1:0]                            adjust,
   output logic                                  ready,
   output mpool_pkg::stat_type                   stat,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [mpool_pkg::SAMPLE_W-1:0] rsp_pooled_value,
   output logic [mpool_pkg::IDX_W-1:0]           rsp_out_row,
   output logic [mpool_pkg::IDX_W-1:0]           rsp_out_col,
   output logic [mpool_pkg::IDX_W-1:0]           rsp_out_channel
);

   localparam int DEPTH = 1 << AW;

   logic [mpool_pkg::SAMPLE_W-1:0] partial_max_ff [0:DEPTH-1];

   logic                                  s1_valid_ff, s1_valid_in;
   logic signed [mpool_pkg::SAMPLE_W-1:0] s1_sample_ff;
   mpool_pkg::win_type                    s1_win_ff;
   logic [AW-1:0]                         s1_slot_ff;
   logic signed [mpool_pkg::SAMPLE_W-1:0] rd_data_ff;
   logic                                  fwd_hit_ff;
   logic signed [mpool_pkg::SAMPLE_W-1:0] fwd_data_ff;
   logic                                  out_valid_ff, out_valid_in;
   logic signed [mpool_pkg::SAMPLE_W-1:0] out_value_ff;
   logic [mpool_pkg::IDX_W-1:0]           out_row_ff, out_col_ff, out_chan_ff;

   logic signed [mpool_pkg::SAMPLE_W-1:0] sample_adj, held, value, result;
   logic                                  s1_result, s1_go;

   always_comb begin
      if (mpool_pkg::adjust_type'(adjust) == mpool_pkg::ADJ_SUB_IN) begin
         sample_adj = sample - mpool_pkg::EMBED_OFFSET;
      end else begin
         sample_adj = sample;
      end
      // The word ahead wrote this slot on the same edge as our read: use its value.
      held  = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
      value = (!s1_win_ff.first && (held > s1_sample_ff)) ? held : s1_sample_ff;
      if (mpool_pkg::adjust_type'(adjust) == mpool_pkg::ADJ_ADD_OUT) begin
         result = value + mpool_pkg::EMBED_OFFSET;
      end else begin
         result = value;
      end
      s1_result = s1_valid_ff && s1_win_ff.last;
      // Words that make no result pass even when the result register is full.
      s1_go     = s1_valid_ff && (!s1_win_ff.last || !out_valid_ff || rsp_ready);
      ready     = !s1_valid_ff || s1_go;
      s1_valid_in  = take || (s1_valid_ff && !s1_go);
      out_valid_in = (s1_go && s1_result) || (out_valid_ff && !rsp_ready);
      stat.s1_valid  = s1_valid_ff;
      stat.s1_result = s1_result;
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_win_ff.hit) begin
         partial_max_ff[s1_slot_ff] <= value;
      end
      if (take) begin
         rd_data_ff <= partial_max_ff[slot];
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_sample_ff <= sample_adj;
         s1_win_ff    <= win;
         s1_slot_ff   <= slot;
         fwd_hit_ff   <= s1_go && s1_win_ff.hit && (s1_slot_ff == slot);
         fwd_data_ff  <= value;
      end
      if (s1_go && s1_result) begin
         out_value_ff <= result;
         out_row_ff   <= s1_win_ff.row;
         out_col_ff   <= s1_win_ff.col;
         out_chan_ff  <= s1_win_ff.chan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pooled_value = out_value_ff;
   assign rsp_out_row      = out_row_ff;
   assign rsp_out_col      = out_col_ff;
   assign rsp_out_channel  = out_chan_ff;

endmodule

[sv/max_pool_2d_stream_top.sv]
`timescale 1ns / 1ps
// Top level of the streaming 2-D max pooling block.
//
//   channel   direction  handshake          word
//   req_      in         req_valid/ready    req_sample
//   rsp_      out        rsp_valid/ready    rsp_pooled_value, rsp_out_row/col/channel
//   csr_      in         csr_we             csr_index, csr_wdata
//
// One sample per cycle sustained while no closing sample is stalled. The accepting edge
// registers the sample together with its memory read (address from the position
// counters); compare and write-back follow in the compare stage and load the result
// register, so a result shows once it has passed both the stage and result registers.
// Reset clears counters, valid flags and the configuration; the partial maximum memory
// is not cleared, each window writes its entry at its first sample.
// A full result register stalls only a sample that closes a window.
module max_pool_2d_stream_top #(
   parameter int MAX_DIM = 64,
   parameter int MAX_CHANNELS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [mpool_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [mpool_pkg::SAMPLE_W-1:0] rsp_pooled_value,
   output logic [mpool_pkg::IDX_W-1:0]           rsp_out_row,
   output logic [mpool_pkg::IDX_W-1:0]           rsp_out_col,
   output logic [mpool_pkg::IDX_W-1:0]           rsp_out_channel,
   input  logic                                  csr_we,
   input  logic [mpool_pkg::CSR_ADDR_W-1:0]      csr_index,
   input  logic [mpool_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int PW = $clog2(MAX_DIM);
   localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   mpool_pkg::cfg_type  cfg_ff, cfg_in;
   mpool_pkg::win_type  win;
   mpool_pkg::stat_type stat;
   logic [PW+CW-1:0]    slot;
   logic                take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (mpool_pkg::reg_index_type'(csr_index))
            mpool_pkg::REG_CHANNEL_COUNT:    cfg_in.channel_count    = csr_wdata;
            mpool_pkg::REG_MAP_HEIGHT:       cfg_in.map_height       = csr_wdata;
            mpool_pkg::REG_MAP_WIDTH:        cfg_in.map_width        = csr_wdata;
            mpool_pkg::REG_POOL_STRIDE:      cfg_in.pool_stride      = csr_wdata[3:0];
            mpool_pkg::REG_POOL_KERNEL:      cfg_in.pool_kernel      = csr_wdata[3:0];
            mpool_pkg::REG_INPUT_TRANSPOSED: cfg_in.input_transposed = csr_wdata[0];
            mpool_pkg::REG_EMBED_ADJUST:     cfg_in.embed_adjust     = csr_wdata[1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= mpool_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign take = req_valid && req_ready;

   mpool_ctrl #(
      .MAX_DIM(MAX_DIM),
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .restart(csr_we),
      .advance(take),
      .cfg(cfg_ff),
      .win(win),
      .slot(slot)
   );

   mpool_datapath #(
      .MAX_DIM(MAX_DIM),
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .take(take),
      .sample(req_sample),
      .win(win),
      .slot(slot),
      .adjust(cfg_ff.embed_adjust),
      .ready(req_ready),
      .stat(stat),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pooled_value(rsp_pooled_value),
      .rsp_out_row(rsp_out_row),
      .rsp_out_col(rsp_out_col),
      .rsp_out_channel(rsp_out_channel)
   );

`ifndef SYNTHESIS
   // Any register write restarts the stream at the first position.
   restart_to_origin: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (win.row == '0 && win.col == '0 && win.chan == '0))
      else $error("stream not restarted after register write");

   // A window result blocked by a full result register must hold off new words.
   stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (stat.s1_result && rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input accepted while result stage is stalled");

   // A new result always comes from a window close in the compare stage.
   result_has_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(stat.s1_result))
      else $error("result appeared without a closing window");
`endif

endmodule
